// ===== sv/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and code-mapping tables for the 3x3 LBP mapper.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int ROW_W      = 12;
    localparam int H_W        = 13;
    localparam int LW_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_MAPPING_MODE = 2'd2,
        REG_RESERVED     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_RAW = 2'd0,
        MODE_ROT = 2'd1,
        MODE_UNI = 2'd2,
        MODE_ALT = 2'd3
    } t_mode;

    typedef logic [255:0][CODE_W-1:0] t_code_tab;

    function automatic logic [CODE_W-1:0] rotr8(input logic [CODE_W-1:0] v);
        return {v[0], v[CODE_W-1:1]};
    endfunction

    function automatic logic [CODE_W-1:0] rot_min(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] best;
        logic [CODE_W-1:0] v;
        best = code;
        v    = code;
        for (int k = 0; k < 7; k++) begin
            v = rotr8(v);
            if (v < best) begin
                best = v;
            end
        end
        return best;
    endfunction

    function automatic logic is_uniform(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] diff;
        int n;
        diff = code ^ rotr8(code);
        n    = 0;
        for (int k = 0; k < CODE_W; k++) begin
            n = n + int'(diff[k]);
        end
        return (n <= 2);
    endfunction

    function automatic t_code_tab build_rot_tab();
        t_code_tab tab;
        for (int c = 0; c < 256; c++) begin
            tab[c] = rot_min(CODE_W'(c));
        end
        return tab;
    endfunction

    function automatic t_code_tab build_uni_tab();
        t_code_tab tab;
        int label;
        label = 1;
        for (int c = 0; c < 256; c++) begin
            if (is_uniform(CODE_W'(c))) begin
                tab[c] = CODE_W'(label);
                label  = label + 1;
            end else begin
                tab[c] = '0;
            end
        end
        return tab;
    endfunction

    localparam t_code_tab ROT_TAB = build_rot_tab();
    localparam t_code_tab UNI_TAB = build_uni_tab();

endpackage

// ===== sv/lbp_3x3_code_mapper.sv =====
// ----------------------------------------------------------------------------
// lbp_3x3_code_mapper
// 3x3 local binary pattern over a greyscale raster stream, with raw,
// rotation-invariant and uniform-label code mapping.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on i_valid / o_stall in raster order; i_frame_start marks the
//   first pixel of a frame. Each interior pixel yields one item on
//   o_valid / i_stall, issued when the pixel one row down and one column right
//   arrives. Border pixels give no item.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set line
//   width, frame height and mapping mode; write them only while idle.
//   Throughput: one pixel per cycle while o_stall is low. Both line stores share
//   one 16-bit-wide synchronous RAM, read on acceptance and written back in the
//   following cycle, with forwarding when the next pixel hits the same column.
//   o_valid rises once the triggering pixel's result has passed the RAM read,
//   compare and code map stages into a 4-entry output FIFO.
//   When the receiver stalls, items collect in the FIFO; o_stall rises once
//   FIFO plus in-flight results reach 4, so nothing is dropped.
//   Reset clears counters, pipeline and FIFO state and loads default
//   configuration (640 x 480, raw). Line store contents are undefined until
//   written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lbp_3x3_code_mapper
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CODE_W-1:0]     o_pattern_code,
    output logic                  o_frame_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int MW = 2 * PIX_W;

    // configuration
    logic [LW_W-1:0]   r_line_width;
    logic [H_W-1:0]    r_frame_height;
    t_mode             r_mode;

    // position counters
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;

    // line stores: {upper, middle}
    logic [MW-1:0]     r_mem [MAX_WIDTH];
    logic [MW-1:0]     r_rd_data;

    // stage 1
    logic              r_s1_valid;
    logic              r_s1_res;
    logic              r_s1_last;
    logic [CW-1:0]     r_s1_addr;
    logic [PIX_W-1:0]  r_s1_pix;
    logic              r_s1_fwd;
    logic [MW-1:0]     r_s1_fwd_data;
    logic [PIX_W-1:0]  r_win [6];

    // stage 2
    logic              r_s2_valid;
    logic              r_s2_last;
    logic [CODE_W-1:0] r_s2_code;

    // output FIFO
    logic [CODE_W:0]      r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;

    logic [WW-1:0]     w_cl;
    logic [H_W-1:0]    h_cl;
    logic              in_fire;
    logic              out_fire;
    logic [CW-1:0]     c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic [WW-1:0]     c_ext;
    logic [WW-1:0]     c_inc;
    logic [H_W-1:0]    r_ext;
    logic [H_W-1:0]    r_inc;
    logic              has_res;
    logic              is_last;
    logic [CW-1:0]     n_col;
    logic [ROW_W-1:0]  n_row;
    logic [PIX_W-1:0]  s1_top;
    logic [PIX_W-1:0]  s1_mid;
    logic [CODE_W-1:0] s1_code;
    logic [CODE_W-1:0] s2_mapped;
    logic [FIFO_CW:0]  occupancy;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_line_width < LW_W'(MIN_DIM)) begin
            w_cl = WW'(MIN_DIM);
        end else if (32'(r_line_width) > 32'(MAX_WIDTH)) begin
            w_cl = WW'(MAX_WIDTH);
        end else begin
            w_cl = WW'(r_line_width);
        end
        if (r_frame_height < H_W'(MIN_DIM)) begin
            h_cl = H_W'(MIN_DIM);
        end else if (r_frame_height > H_W'(MAX_HEIGHT)) begin
            h_cl = H_W'(MAX_HEIGHT);
        end else begin
            h_cl = r_frame_height;
        end
    end

    assign occupancy = (FIFO_CW+1)'(r_count) + (FIFO_CW+1)'(r_s1_valid & r_s1_res)
                     + (FIFO_CW+1)'(r_s2_valid);
    assign o_stall   = (occupancy >= (FIFO_CW+1)'(FIFO_DEPTH));
    assign in_fire   = i_valid & ~o_stall;
    assign o_valid   = (r_count != '0);
    assign out_fire  = o_valid & ~i_stall;

    always_comb begin
        c_cur   = i_frame_start ? '0 : r_col;
        r_cur   = i_frame_start ? '0 : r_row;
        c_ext   = WW'(c_cur);
        r_ext   = H_W'(r_cur);
        c_inc   = c_ext + WW'(1);
        r_inc   = r_ext + H_W'(1);
        has_res = (c_ext < w_cl) && (r_ext < h_cl)
                && (c_ext >= WW'(2)) && (r_ext >= H_W'(2));
        is_last = (c_ext == w_cl - WW'(1)) && (r_ext == h_cl - H_W'(1));
        if (c_inc >= w_cl) begin
            n_col = '0;
            n_row = (r_inc >= h_cl) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            n_col = c_inc[CW-1:0];
            n_row = r_cur;
        end
    end

    // stage 1: line store data with forwarding, window compare
    always_comb begin
        {s1_top, s1_mid} = r_s1_fwd ? r_s1_fwd_data : r_rd_data;
        s1_code[7] = (r_win[0] >= r_win[4]);
        s1_code[6] = (r_win[3] >= r_win[4]);
        s1_code[5] = (s1_top   >= r_win[4]);
        s1_code[4] = (s1_mid   >= r_win[4]);
        s1_code[3] = (r_s1_pix >= r_win[4]);
        s1_code[2] = (r_win[5] >= r_win[4]);
        s1_code[1] = (r_win[2] >= r_win[4]);
        s1_code[0] = (r_win[1] >= r_win[4]);
    end

    always_comb begin
        case (r_mode)
            MODE_ROT: s2_mapped = ROT_TAB[r_s2_code];
            MODE_UNI: s2_mapped = UNI_TAB[r_s2_code];
            default:  s2_mapped = r_s2_code;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_data <= r_mem[c_cur];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_addr] <= {s1_mid, r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LW_W'(640);
            r_frame_height <= H_W'(480);
            r_mode         <= MODE_RAW;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LW_W-1:0];
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[H_W-1:0];
                    REG_MAPPING_MODE: r_mode         <= t_mode'(i_cfg_data[1:0]);
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_valid <= in_fire;
            r_s2_valid <= r_s1_valid & r_s1_res;
            if (r_s2_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CW'(r_s2_valid) - FIFO_CW'(out_fire);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_res      <= has_res;
            r_s1_last     <= is_last;
            r_s1_addr     <= c_cur;
            r_s1_pix      <= i_pixel;
            r_s1_fwd      <= r_s1_valid && (r_s1_addr == c_cur);
            r_s1_fwd_data <= {s1_mid, r_s1_pix};
        end
        if (r_s1_valid) begin
            r_win[0]  <= r_win[3];
            r_win[1]  <= r_win[4];
            r_win[2]  <= r_win[5];
            r_win[3]  <= s1_top;
            r_win[4]  <= s1_mid;
            r_win[5]  <= r_s1_pix;
            r_s2_code <= s1_code;
            r_s2_last <= r_s1_last;
        end
        if (r_s2_valid) begin
            r_fifo[r_wr_ptr] <= {r_s2_last, s2_mapped};
        end
    end

    assign {o_frame_last, o_pattern_code} = r_fifo[r_rd_ptr];

endmodule
